// ===== sv/seven_segment_mux_driver_core_assert.svh =====
// assertion macros for the seven-segment multiplexer core
`ifndef SEVEN_SEGMENT_MUX_DRIVER_CORE_ASSERT_SVH
`define SEVEN_SEGMENT_MUX_DRIVER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SSMD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked outside reset
`define SSMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== sv/ssmd_pkg.sv =====
// shared types, codes, segment table and conversion helpers
package ssmd_pkg;

    localparam int CMD_W   = 2;
    localparam int VALUE_W = 17;
    localparam int MODE_W  = 3;
    localparam int DIGITS  = 4;
    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    typedef logic [7:0]         t_seg;
    typedef logic [CMD_W-1:0]   t_cmd;
    typedef logic [MODE_W-1:0]  t_mode;

    localparam t_cmd CMD_LOAD_DEC = 2'd0;
    localparam t_cmd CMD_LOAD_HEX = 2'd1;
    localparam t_cmd CMD_REFRESH  = 2'd2;

    localparam t_mode MODE_RESET   = 3'd1;
    localparam t_mode MODE_ALL_DP  = 3'd5;

    localparam int DEC_MOD  = 10000;
    localparam int THOUSAND = 1000;
    localparam int HUNDRED  = 100;
    localparam int TEN      = 10;

    localparam t_seg SEG_TABLE [16] = '{
        8'hFC, 8'h0C, 8'hDA, 8'h9E, 8'h2E, 8'hB6, 8'hF6, 8'h1C,
        8'hFE, 8'hBE, 8'h7E, 8'hE6, 8'hF0, 8'hCE, 8'hF2, 8'h72
    };

    // value mod 10000 by parallel compares against the multiples
    function automatic logic [13:0] f_mod_dec(input logic [VALUE_W-1:0] v);
        logic [3:0]         q;
        logic [VALUE_W-1:0] prod;
        q = '0;
        for (int k = 1; k <= 13; k++) begin
            if (v >= VALUE_W'(k * DEC_MOD)) q = 4'(k);
        end
        prod = VALUE_W'(int'(q) * DEC_MOD);
        return 14'(v - prod);
    endfunction

    // one decimal digit of x for a constant place weight, x below ten weights
    function automatic logic [3:0] f_digit(input logic [13:0] x, input int unit);
        logic [3:0] q;
        q = '0;
        for (int k = 1; k <= 9; k++) begin
            if (x >= 14'(k * unit)) q = 4'(k);
        end
        return q;
    endfunction

    function automatic logic [13:0] f_rem(input logic [13:0] x, input logic [3:0] d,
                                          input int unit);
        return 14'(x - 14'(int'(d) * unit));
    endfunction

endpackage

// ===== sv/seven_segment_mux_driver_core.sv =====
// seven-segment multiplexer core: digit conversion pipeline, pattern store and scan output
//
//  channel   | dir | handshake                     | payload
//  ----------+-----+-------------------------------+-------------------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | tdata: value; tuser: cmd
//  m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: segments, digit_enable
//  cfg       | in  | i_cfg_valid / o_cfg_ready     | i_cfg_data: mode_indicator
//
// one transaction per cycle sustained while the pipeline is not held; a refresh result passes through
// the input register, modulo step, thousands step, hundreds step, then the result register
// i_rst_n is synchronous: clears the pipeline, the stored patterns, the scan position
// and sets the mode to 1; cfg writes are always taken
// the whole pipeline holds only while a refresh waits at the last step and the result
// register is full and not taken; s_axis_tready follows that hold
module seven_segment_mux_driver_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ssmd_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // [16:0] value, rest zero
    input  logic [ssmd_pkg::CMD_W-1:0]         s_axis_tuser,  // [1:0] cmd
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [ssmd_pkg::OUT_DATA_W-1:0]    m_axis_tdata,  // [7:0] segments,
                                                              // [11:8] digit_enable, rest zero
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ssmd_pkg::MODE_W-1:0]        i_cfg_data
);
    import ssmd_pkg::*;

    `include "seven_segment_mux_driver_core_assert.svh"

    // control
    logic        r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_out_vld;
    logic [1:0]  r_scan;
    t_mode       r_mode;
    t_seg        r_pat [DIGITS];

    // payload
    t_cmd               r_a_cmd, r_b_cmd, r_c_cmd, r_d_cmd;
    logic [VALUE_W-1:0] r_a_val;
    logic [15:0]        r_b_hex, r_c_hex, r_d_hex;
    logic [13:0]        r_b_rem;
    logic [9:0]         r_c_rem;
    logic [6:0]         r_d_rem;
    logic [3:0]         r_c_d3, r_d_d3, r_d_d2;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic        w_adv;
    logic        w_d_refresh;
    logic        w_d_load;
    logic [3:0]  w_c_d3, w_d_d2, w_d_d1, w_d_d0;
    logic [13:0] w_c_rem, w_d_rem;
    logic [15:0] w_nib;
    logic [1:0]  n_scan;
    logic        w_dp;
    t_seg        w_seg;
    logic [3:0]  w_en;

    assign w_d_refresh = r_d_vld && (r_d_cmd == CMD_REFRESH);
    assign w_d_load    = r_d_vld && ((r_d_cmd == CMD_LOAD_DEC) || (r_d_cmd == CMD_LOAD_HEX));
    assign w_adv       = !(w_d_refresh && r_out_vld && !m_axis_tready);

    assign s_axis_tready = w_adv;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    // digit steps
    assign w_c_d3  = f_digit(r_b_rem, THOUSAND);
    assign w_c_rem = f_rem(r_b_rem, w_c_d3, THOUSAND);
    assign w_d_d2  = f_digit({4'd0, r_c_rem}, HUNDRED);
    assign w_d_rem = f_rem({4'd0, r_c_rem}, w_d_d2, HUNDRED);
    assign w_d_d1  = f_digit({7'd0, r_d_rem}, TEN);
    assign w_d_d0  = 4'(f_rem({7'd0, r_d_rem}, w_d_d1, TEN));

    assign w_nib = (r_d_cmd == CMD_LOAD_HEX) ? r_d_hex : {r_d_d3, r_d_d2, w_d_d1, w_d_d0};

    // scan position moves first, then that digit is shown
    assign n_scan = r_scan + 2'd1;

    always_comb begin
        w_dp = 1'b0;
        if (r_mode == MODE_ALL_DP) begin
            w_dp = 1'b1;
        end else if ((r_mode != '0) && (r_mode < MODE_ALL_DP)) begin
            w_dp = (2'(r_mode - 3'd1) == n_scan);
        end
    end

    assign w_seg = r_pat[n_scan] | {7'd0, w_dp};
    assign w_en  = 4'd1 << n_scan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_d_vld   <= 1'b0;
            r_out_vld <= 1'b0;
            r_scan    <= '0;
            r_mode    <= MODE_RESET;
            for (int i = 0; i < DIGITS; i++) begin
                r_pat[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            // a new refresh result refills the register in the cycle the old one leaves
            if (w_adv && w_d_refresh) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
            if (w_adv) begin
                r_a_vld <= s_axis_tvalid;
                r_b_vld <= r_a_vld;
                r_c_vld <= r_b_vld;
                r_d_vld <= r_c_vld;
                if (w_d_load) begin
                    for (int i = 0; i < DIGITS; i++) begin
                        r_pat[i] <= SEG_TABLE[w_nib[4*i +: 4]];
                    end
                end
                if (w_d_refresh) begin
                    r_scan <= n_scan;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_cmd <= s_axis_tuser;
            r_a_val <= s_axis_tdata[VALUE_W-1:0];
            r_b_cmd <= r_a_cmd;
            r_b_hex <= r_a_val[15:0];
            r_b_rem <= f_mod_dec(r_a_val);
            r_c_cmd <= r_b_cmd;
            r_c_hex <= r_b_hex;
            r_c_d3  <= w_c_d3;
            r_c_rem <= w_c_rem[9:0];
            r_d_cmd <= r_c_cmd;
            r_d_hex <= r_c_hex;
            r_d_d3  <= r_c_d3;
            r_d_d2  <= w_d_d2;
            r_d_rem <= w_d_rem[6:0];
            if (w_d_refresh) begin
                r_out_data <= {4'd0, w_en, w_seg};
            end
        end
    end

    `SSMD_ASSERT_NOW(a_enable_onehot, i_clk, i_rst_n, m_axis_tvalid, $onehot(m_axis_tdata[11:8]))
    `SSMD_ASSERT_NOW(a_hold_cause, i_clk, i_rst_n, !w_adv, r_out_vld && w_d_refresh)
    `SSMD_ASSERT_NEXT(a_refresh_out, i_clk, i_rst_n, w_adv && w_d_refresh, m_axis_tvalid)
    `SSMD_ASSERT_NEXT(a_scan_step, i_clk, i_rst_n, w_adv && w_d_refresh,
        r_scan == $past(r_scan) + 2'd1)

endmodule

// ===== bench/tb_seven_segment_mux_driver_core.sv =====
// self-checking bench for the seven-segment multiplexer core
`timescale 1ns / 1ps

module tb_seven_segment_mux_driver_core;
    import ssmd_pkg::*;

    localparam t_cmd CMD_UNUSED  = 2'd3;
    localparam t_mode DP_ONE_LO  = 3'd1;
    localparam t_mode DP_ONE_HI  = 3'd4;
    localparam int DEC_BASE      = 10000;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 244;
    localparam int DRAIN_CYCLES  = 12;
    localparam int LONG_HOLD     = 400;
    localparam int MAX_REPORTS   = 10;

    // segment glyphs for nibble values 0..f
    localparam t_seg GLYPH [16] = '{
        8'hFC, 8'h0C, 8'hDA, 8'h9E, 8'h2E, 8'hB6, 8'hF6, 8'h1C,
        8'hFE, 8'hBE, 8'h7E, 8'hE6, 8'hF0, 8'hCE, 8'hF2, 8'h72
    };

    typedef struct packed {
        t_cmd               cmd;
        logic [VALUE_W-1:0] val;
    } t_stim;

    typedef struct packed {
        t_seg       seg;
        logic [3:0] en;
    } t_scan_out;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [16:0] value, rest zero
    logic [CMD_W-1:0]      s_axis_tuser = '0;   // [1:0] cmd
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;        // [7:0] segments, [11:8] digit_enable
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [MODE_W-1:0]     i_cfg_data = MODE_RESET;

    // predictor state
    t_seg       glyph_mem [DIGITS];
    logic [1:0] digit_sel;
    t_mode      dp_mode;

    t_stim     pend_q [$];
    t_scan_out scan_exp_q [$];

    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;
    bit          src_pause = 1'b0;
    bit          hold_req = 1'b0;
    int          hold_left = 0;
    int          fault_cnt = 0;

    seven_segment_mux_driver_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("seven_segment_mux_driver_core test failed");
        $finish;
    end

    // works out the scan output that an accepted transaction causes
    function automatic void predict_scan(input t_cmd op, input logic [VALUE_W-1:0] v);
        int unsigned rem;
        bit          lit;
        t_scan_out   r;
        case (op)
            CMD_LOAD_DEC: begin
                rem = v % DEC_BASE;
                glyph_mem[3] = GLYPH[rem / 1000];
                glyph_mem[2] = GLYPH[(rem / 100) % 10];
                glyph_mem[1] = GLYPH[(rem / 10) % 10];
                glyph_mem[0] = GLYPH[rem % 10];
            end
            CMD_LOAD_HEX: begin
                for (int i = 0; i < DIGITS; i++)
                    glyph_mem[i] = GLYPH[v[4*i +: 4]];
            end
            CMD_REFRESH: begin
                digit_sel = digit_sel + 2'd1;
                lit = (dp_mode == MODE_ALL_DP) ||
                      (dp_mode >= DP_ONE_LO && dp_mode <= DP_ONE_HI &&
                       (dp_mode - 3'd1) == 3'(digit_sel));
                r.seg = glyph_mem[digit_sel] | t_seg'(lit);
                r.en  = 4'b0001 << digit_sel;
                scan_exp_q.push_back(r);
            end
            default: ;
        endcase
    endfunction

    function automatic t_stim mk_item(input t_cmd op, input logic [VALUE_W-1:0] v);
        t_stim s;
        s.cmd = op;
        s.val = v;
        return s;
    endfunction

    function automatic logic [VALUE_W-1:0] rand_value();
        case ($urandom_range(3))
            0: return VALUE_W'($urandom_range(DEC_BASE - 1));
            1: return VALUE_W'(DEC_BASE * $urandom_range(1, 13) - $urandom_range(1));
            default: return VALUE_W'($urandom);
        endcase
    endfunction

    // usually a load, then a run of refreshes; now and then an unused command goes first
    task automatic queue_burst(inout int made);
        int n;
        if ($urandom_range(9) == 0)
            pend_q.push_back(mk_item(CMD_UNUSED, rand_value()));
        if ($urandom_range(9) < 8) begin
            pend_q.push_back(mk_item($urandom_range(1) ? CMD_LOAD_HEX : CMD_LOAD_DEC,
                                     rand_value()));
            made++;
        end
        n = $urandom_range(1, 8);
        repeat (n) begin
            pend_q.push_back(mk_item(CMD_REFRESH, VALUE_W'($urandom)));
            made++;
        end
    endtask

    task automatic wait_drained();
        while (pend_q.size() != 0 || s_axis_tvalid || scan_exp_q.size() != 0)
            @(negedge i_clk);
        // loads can still be in the pipeline with nothing expected
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_mode(input t_mode m);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        dp_mode = m;
        @(negedge i_clk);
    endtask

    task automatic note_fault(input string msg);
        if (fault_cnt < MAX_REPORTS)
            $display("%0t: %s", $realtime, msg);
        fault_cnt++;
    endtask

    // source side
    always @(posedge i_clk) begin : drive_proc
        t_stim nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                predict_scan(s_axis_tuser, s_axis_tdata[VALUE_W-1:0]);
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pend_q.size() != 0 && !src_pause && $urandom_range(99) >= src_idle_pct) begin
                    nxt = pend_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= IN_DATA_W'(nxt.val);
                    s_axis_tuser  <= nxt.cmd;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_req && hold_left == 0)
            hold_left <= LONG_HOLD;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // sink side and checking
    always @(posedge i_clk) begin : watch_proc
        t_scan_out want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (scan_exp_q.size() == 0) begin
                    note_fault($sformatf("unexpected transaction seg=%02h en=%01h",
                                         m_axis_tdata[7:0], m_axis_tdata[11:8]));
                end else begin
                    want = scan_exp_q.pop_front();
                    if (m_axis_tdata[7:0] !== want.seg || m_axis_tdata[11:8] !== want.en)
                        note_fault($sformatf("mismatch seg exp %02h got %02h, en exp %01h got %01h",
                                             want.seg, m_axis_tdata[7:0],
                                             want.en, m_axis_tdata[11:8]));
                end
            end
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= snk_stall_pct);
        end
    end

    initial begin : main_seq
        t_mode mode_plan [PHASES];
        int    made;
        mode_plan = '{MODE_ALL_DP, 3'd0, 3'd1, 3'd4, 3'd7, 3'd2, 3'd6, 3'd3};
        for (int i = 0; i < DIGITS; i++)
            glyph_mem[i] = '0;
        digit_sel = '0;
        dp_mode   = MODE_RESET;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: scan before any load, range extremes, unused command
        repeat (4) pend_q.push_back(mk_item(CMD_REFRESH, '0));
        pend_q.push_back(mk_item(CMD_LOAD_DEC, 17'h1FFFF));
        repeat (4) pend_q.push_back(mk_item(CMD_REFRESH, 17'h1FFFF));
        pend_q.push_back(mk_item(CMD_LOAD_HEX, 17'h1FFFF));
        pend_q.push_back(mk_item(CMD_REFRESH, '0));
        pend_q.push_back(mk_item(CMD_UNUSED, 17'h1FFFF));
        repeat (3) pend_q.push_back(mk_item(CMD_REFRESH, '0));
        pend_q.push_back(mk_item(CMD_LOAD_DEC, 17'd9999));
        pend_q.push_back(mk_item(CMD_REFRESH, '0));
        pend_q.push_back(mk_item(CMD_LOAD_DEC, 17'd10000));
        pend_q.push_back(mk_item(CMD_REFRESH, '0));
        pend_q.push_back(mk_item(CMD_LOAD_HEX, 17'h0BA98));
        repeat (2) pend_q.push_back(mk_item(CMD_REFRESH, '0));

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            write_mode(mode_plan[ph]);
            case (ph % 4)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
                1: begin src_idle_pct = 72; snk_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  snk_stall_pct = 72; end
                default: begin src_idle_pct = 24; snk_stall_pct = 24; end
            endcase
            made = 0;
            while (made < PHASE_ITEMS)
                queue_burst(made);
            if (ph == 0) begin
                // receiver holds off while the source keeps offering
                hold_req = 1'b1;
                @(negedge i_clk);
                hold_req = 1'b0;
            end
            if (ph == 3) begin
                while (pend_q.size() > PHASE_ITEMS / 2)
                    @(negedge i_clk);
                src_pause = 1'b1;
                while (scan_exp_q.size() != 0 || s_axis_tvalid)
                    @(negedge i_clk);
                src_pause = 1'b0;
            end
        end

        wait_drained();
        if (scan_exp_q.size() != 0)
            note_fault("transactions still expected at the end");
        if (fault_cnt == 0) begin
            $display("seven_segment_mux_driver_core test passed");
        end else begin
            $display("seven_segment_mux_driver_core test failed");
        end
        $finish;
    end

endmodule

// ===== seven_segment_mux_driver_core.f =====
+incdir+sv
sv/ssmd_pkg.sv
sv/seven_segment_mux_driver_core.sv
bench/tb_seven_segment_mux_driver_core.sv
